// ----- rtl/core/bbpt_pkg.sv -----
package bbpt_pkg;

	localparam int TESS_W      = 7;
	localparam int MAX_TESS    = 64;
	localparam int TESS_RESET  = 10;
	localparam int TESS_MIN    = 2;
	localparam int CTRL_POINTS = 16;
	localparam int SLOT_W      = 4;
	localparam int IDX_W       = 6;
	localparam int COORD_W     = 32;
	localparam int T_W         = 17;
	localparam int FRAC_W      = 16;
	localparam int COEF_W      = 36;
	localparam int MAG_W       = 35;
	localparam int PROD_W      = MAG_W + T_W;
	localparam int ACC_W       = 38;
	localparam int DIV_STEPS   = 16;
	localparam int CORNERS     = 6;
	localparam int STAGES      = 4;

	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_CELL   = 1'b1;
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_OOR = 1'b1;

	typedef struct packed {
		logic                      req_type;
		logic [SLOT_W-1:0]         point_slot;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
		logic [IDX_W-1:0]          cell_row;
		logic [IDX_W-1:0]          cell_col;
	} req_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] vert_x;
		logic signed [COORD_W-1:0] vert_y;
		logic signed [COORD_W-1:0] vert_z;
		logic [2:0]                corner;
		logic                      status;
		logic                      last;
	} res_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_WRITE,
		OP_LOAD,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_TWR,
		OP_POW2,
		OP_POW3,
		OP_RD,
		OP_MUL,
		OP_SUM,
		OP_EMIT,
		OP_ERR
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] pidx;
		logic [1:0] pt;
		logic [1:0] crd;
		logic [2:0] stage;
		logic [2:0] step;
	} cmd_t;

	typedef struct packed {
		logic oor;
	} sts_t;

	// Grid point used by each corner of the two triangles.
	function automatic logic [1:0] corner_point(input logic [2:0] c);
		logic [1:0] p;
		case (c)
			3'd0: p = 2'd0;
			3'd1: p = 2'd1;
			3'd2: p = 2'd2;
			3'd3: p = 2'd1;
			3'd4: p = 2'd3;
			3'd5: p = 2'd2;
			default: p = 2'd0;
		endcase
		return p;
	endfunction

endpackage

// ----- rtl/core/bicubic_bezier_patch_tessellator_top.sv -----
// Channel  | Ports                            | Handshake
// ---------+----------------------------------+------------------------------------------
// request  | start, busy, req                 | item taken at a clock edge with start high
//          |                                  | and busy low
// result   | res_stb, res                     | item shown for one cycle with res_stb high
// config   | cfg_we, cfg_wdata                | tess_level written on any edge with cfg_we
//
// A control point write keeps busy low, so writes can follow each other on every
// clock. A cell item keeps busy high through a range check state, four parameter
// steps (a division, then the powers), sixty cubic evaluations through the one
// shared multiplier, then six result states. Each result item shows in the cycle
// after its result state, the last in the first idle cycle. An out of range cell
// answers with its single error item after the check and error states.
// The asynchronous reset clears the controller and sets tess_level to ten; the
// control point memory holds nothing defined until written. The receiver cannot
// stall, so each result item is simply presented for one cycle.
module bicubic_bezier_patch_tessellator_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  bbpt_pkg::req_t              req,
	input  logic                        cfg_we,
	input  logic [bbpt_pkg::TESS_W-1:0] cfg_wdata,
	output logic                        res_stb,
	output bbpt_pkg::res_t              res
);

	// Commands flow from the sequencer to the datapath; only the range check
	// result flows back.
	bbpt_pkg::cmd_t cmd;
	bbpt_pkg::sts_t sts;

	bbpt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req_type(req.req_type),
		.sts     (sts),
		.busy    (busy),
		.cmd     (cmd)
	);

	bbpt_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req      (req),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.sts      (sts),
		.res      (res),
		.res_stb  (res_stb)
	);

`ifndef SYNTHESIS
	// A result item only ever follows a cycle in which the sequencer was working.
	a_res_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_stb |-> $past(busy))
		else $error("result item without preceding work");

	// The final item of a request appears once the sequencer is back at rest.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_stb && res.last |-> !busy)
		else $error("last item shown while still busy");

	// An error item is always alone and carries corner zero.
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_stb && res.status |-> res.last && res.corner == 3'd0)
		else $error("malformed error item");
`endif

endmodule

// ----- rtl/core/bbpt_ram.sv -----
module bbpt_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/core/bbpt_ctrl.sv -----
module bbpt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            req_type,
	input  bbpt_pkg::sts_t  sts,
	output logic            busy,
	output bbpt_pkg::cmd_t  cmd
);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_CHECK = 9'b000000010,
		S_DIV   = 9'b000000100,
		S_POW   = 9'b000001000,
		S_RD    = 9'b000010000,
		S_MUL   = 9'b000100000,
		S_SUM   = 9'b001000000,
		S_EMIT  = 9'b010000000,
		S_ERR   = 9'b100000000
	} state_t;

	state_t     state_q;
	logic [1:0] pidx_q;
	logic [1:0] pt_q;
	logic [1:0] crd_q;
	logic [2:0] stage_q;
	logic [4:0] cnt_q;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd.op    = bbpt_pkg::OP_NONE;
		cmd.pidx  = pidx_q;
		cmd.pt    = pt_q;
		cmd.crd   = crd_q;
		cmd.stage = stage_q;
		cmd.step  = cnt_q[2:0];
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op = (req_type == bbpt_pkg::REQ_CELL) ? bbpt_pkg::OP_LOAD
					                                          : bbpt_pkg::OP_WRITE;
				end
			end
			S_DIV: begin
				cmd.op = (cnt_q == 5'd0) ? bbpt_pkg::OP_DIV_INIT : bbpt_pkg::OP_DIV_STEP;
			end
			S_POW: begin
				if (cnt_q == 5'd0) begin
					cmd.op = bbpt_pkg::OP_TWR;
				end else if (cnt_q == 5'd1) begin
					cmd.op = bbpt_pkg::OP_POW2;
				end else if (cnt_q == 5'd3) begin
					cmd.op = bbpt_pkg::OP_POW3;
				end
			end
			S_RD:   cmd.op = bbpt_pkg::OP_RD;
			S_MUL:  cmd.op = bbpt_pkg::OP_MUL;
			S_SUM:  cmd.op = bbpt_pkg::OP_SUM;
			S_EMIT: cmd.op = bbpt_pkg::OP_EMIT;
			S_ERR:  cmd.op = bbpt_pkg::OP_ERR;
			default: cmd.op = bbpt_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pidx_q  <= '0;
			pt_q    <= '0;
			crd_q   <= '0;
			stage_q <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start && req_type == bbpt_pkg::REQ_CELL) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					cnt_q  <= '0;
					pidx_q <= '0;
					state_q <= sts.oor ? S_ERR : S_DIV;
				end
				S_DIV: begin
					if (cnt_q == 5'(bbpt_pkg::DIV_STEPS)) begin
						cnt_q   <= '0;
						state_q <= S_POW;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				S_POW: begin
					if (cnt_q == 5'd3) begin
						cnt_q <= '0;
						if (pidx_q == 2'd3) begin
							pt_q    <= '0;
							crd_q   <= '0;
							stage_q <= '0;
							state_q <= S_RD;
						end else begin
							pidx_q  <= pidx_q + 2'd1;
							state_q <= S_DIV;
						end
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				S_RD: begin
					if (cnt_q == 5'd4) begin
						cnt_q   <= '0;
						state_q <= S_MUL;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				S_MUL: begin
					if (cnt_q == 5'd3) begin
						cnt_q   <= '0;
						state_q <= S_SUM;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				S_SUM: begin
					state_q <= S_RD;
					if (stage_q != 3'(bbpt_pkg::STAGES)) begin
						stage_q <= stage_q + 3'd1;
					end else begin
						stage_q <= '0;
						if (crd_q != 2'd2) begin
							crd_q <= crd_q + 2'd1;
						end else begin
							crd_q <= '0;
							if (pt_q != 2'd3) begin
								pt_q <= pt_q + 2'd1;
							end else begin
								state_q <= S_EMIT;
							end
						end
					end
				end
				S_EMIT: begin
					if (cnt_q == 5'(bbpt_pkg::CORNERS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				S_ERR: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/bbpt_dp.sv -----
module bbpt_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bbpt_pkg::cmd_t                    cmd,
	input  bbpt_pkg::req_t                    req,
	input  logic                              cfg_we,
	input  logic [bbpt_pkg::TESS_W-1:0]       cfg_wdata,
	output bbpt_pkg::sts_t                    sts,
	output bbpt_pkg::res_t                    res,
	output logic                              res_stb
);

	localparam int CW = bbpt_pkg::COORD_W;
	localparam int TW = bbpt_pkg::T_W;
	localparam int AW = bbpt_pkg::ACC_W;

	typedef enum logic [1:0] {MD_ACC, MD_T2, MD_T3} mdst_t;

	logic [bbpt_pkg::TESS_W-1:0] tess_q;
	logic [bbpt_pkg::TESS_W-1:0] den;
	logic [bbpt_pkg::IDX_W-1:0]  row_q, col_q;
	logic [bbpt_pkg::TESS_W-1:0] rem_q;
	logic [TW-1:0]               quo_q;
	logic [TW-1:0]               tp_q [4][3];
	logic signed [CW-1:0]        p_q [4];
	logic signed [CW-1:0]        rowv_q [4];
	logic signed [CW-1:0]        pts_q [4][3];
	logic signed [AW-1:0]        acc_q;
	logic [bbpt_pkg::PROD_W-1:0] prod_s1;
	logic                        neg_s1, vld_s1;
	mdst_t                       dst_s1;
	logic [1:0]                  pidx_s1;
	bbpt_pkg::res_t              res_q;
	logic                        res_stb_q;

	logic [3*CW-1:0]             rdata;
	logic [bbpt_pkg::TESS_W-1:0] idx, rem_init;
	logic                        ge_init, ge_step;
	logic [bbpt_pkg::TESS_W:0]   rem2;
	logic signed [bbpt_pkg::COEF_W-1:0] s0, s1, s2, s3, ca, cb, cc, coef, coef_neg;
	logic [1:0]                  tsel, tidx;
	logic [TW-1:0]               tpw;
	logic [bbpt_pkg::MAG_W-1:0]  mul_a;
	logic [TW-1:0]               mul_b;
	logic                        mul_go, mul_neg;
	mdst_t                       mul_dst;
	logic [bbpt_pkg::COEF_W-1:0] sh;
	logic signed [CW-1:0]        sat;
	logic [1:0]                  kcap;
	logic [1:0]                  epnt;

	assign den = tess_q - 7'd1;

	always_comb begin
		case (cmd.pidx)
			2'd0: idx = {1'b0, row_q};
			2'd1: idx = {1'b0, row_q} + 7'd1;
			2'd2: idx = {1'b0, col_q};
			2'd3: idx = {1'b0, col_q} + 7'd1;
			default: idx = '0;
		endcase
	end

	assign ge_init  = (idx >= den);
	assign rem_init = ge_init ? (idx - den) : idx;
	assign rem2     = {rem_q, 1'b0};
	assign ge_step  = (rem2 >= {1'b0, den});

	assign sts.oor = ({1'b0, row_q} >= den) || ({1'b0, col_q} >= den);

	// Power-basis coefficients of the cubic held in p_q.
	assign s0 = bbpt_pkg::COEF_W'(p_q[0]);
	assign s1 = bbpt_pkg::COEF_W'(p_q[1]);
	assign s2 = bbpt_pkg::COEF_W'(p_q[2]);
	assign s3 = bbpt_pkg::COEF_W'(p_q[3]);
	assign ca = s3 - s0 + (s1 + s1 + s1) - (s2 + s2 + s2);
	assign cb = (s0 + s0 + s0) - (s1 + s1 + s1 + s1 + s1 + s1) + (s2 + s2 + s2);
	assign cc = (s1 + s1 + s1) - (s0 + s0 + s0);

	assign tsel = (cmd.stage == 3'(bbpt_pkg::STAGES)) ? {1'b1, cmd.pt[1]} : {1'b0, cmd.pt[0]};
	assign tidx = (cmd.op == bbpt_pkg::OP_MUL) ? tsel : cmd.pidx;

	always_comb begin
		case (cmd.step)
			3'd0: begin
				coef = ca;
				tpw  = tp_q[tidx][2];
			end
			3'd1: begin
				coef = cb;
				tpw  = tp_q[tidx][1];
			end
			default: begin
				coef = cc;
				tpw  = tp_q[tidx][0];
			end
		endcase
	end

	assign coef_neg = -coef;

	always_comb begin
		mul_go  = 1'b0;
		mul_neg = 1'b0;
		mul_dst = MD_ACC;
		mul_a   = bbpt_pkg::MAG_W'(tp_q[tidx][0]);
		mul_b   = tp_q[tidx][0];
		case (cmd.op)
			bbpt_pkg::OP_MUL: begin
				mul_go  = (cmd.step < 3'd3);
				mul_neg = coef[bbpt_pkg::COEF_W-1];
				mul_a   = mul_neg ? coef_neg[bbpt_pkg::MAG_W-1:0] : coef[bbpt_pkg::MAG_W-1:0];
				mul_b   = tpw;
			end
			bbpt_pkg::OP_POW2: begin
				mul_go  = 1'b1;
				mul_dst = MD_T2;
			end
			bbpt_pkg::OP_POW3: begin
				mul_go  = 1'b1;
				mul_dst = MD_T3;
				mul_a   = bbpt_pkg::MAG_W'(tp_q[tidx][1]);
			end
			default: mul_go = 1'b0;
		endcase
	end

	assign sh = prod_s1[bbpt_pkg::PROD_W-1:bbpt_pkg::FRAC_W];

	always_comb begin
		if (acc_q > AW'(64'sd2147483647)) begin
			sat = 32'sh7FFFFFFF;
		end else if (acc_q < -AW'(64'sd2147483648)) begin
			sat = 32'sh80000000;
		end else begin
			sat = acc_q[CW-1:0];
		end
	end

	assign kcap = cmd.step[1:0] - 2'd1;
	assign epnt = bbpt_pkg::corner_point(cmd.step);

	bbpt_ram #(
		.WIDTH(3 * CW),
		.DEPTH(bbpt_pkg::CTRL_POINTS)
	) u_ctrl_ram (
		.clk  (clk),
		.we   (cmd.op == bbpt_pkg::OP_WRITE),
		.waddr(req.point_slot),
		.wdata({req.point_z, req.point_y, req.point_x}),
		.raddr({cmd.stage[1:0], cmd.step[1:0]}),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tess_q    <= bbpt_pkg::TESS_W'(bbpt_pkg::TESS_RESET);
			vld_s1    <= 1'b0;
			res_stb_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_wdata < bbpt_pkg::TESS_W'(bbpt_pkg::TESS_MIN)) begin
					tess_q <= bbpt_pkg::TESS_W'(bbpt_pkg::TESS_MIN);
				end else if (cfg_wdata > bbpt_pkg::TESS_W'(bbpt_pkg::MAX_TESS)) begin
					tess_q <= bbpt_pkg::TESS_W'(bbpt_pkg::MAX_TESS);
				end else begin
					tess_q <= cfg_wdata;
				end
			end
			vld_s1    <= mul_go;
			res_stb_q <= (cmd.op == bbpt_pkg::OP_EMIT) || (cmd.op == bbpt_pkg::OP_ERR);
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		neg_s1  <= mul_neg;
		dst_s1  <= mul_dst;
		pidx_s1 <= cmd.pidx;

		if (vld_s1 && dst_s1 == MD_T2) begin
			tp_q[pidx_s1][1] <= sh[TW-1:0];
		end
		if (vld_s1 && dst_s1 == MD_T3) begin
			tp_q[pidx_s1][2] <= sh[TW-1:0];
		end

		if (cmd.op == bbpt_pkg::OP_MUL && cmd.step == 3'd0) begin
			acc_q <= AW'(p_q[0]);
		end else if (vld_s1 && dst_s1 == MD_ACC) begin
			acc_q <= neg_s1 ? (acc_q - AW'(sh)) : (acc_q + AW'(sh));
		end

		case (cmd.op)
			bbpt_pkg::OP_LOAD: begin
				row_q <= req.cell_row;
				col_q <= req.cell_col;
			end
			bbpt_pkg::OP_DIV_INIT: begin
				rem_q <= rem_init;
				quo_q <= TW'(ge_init);
			end
			bbpt_pkg::OP_DIV_STEP: begin
				rem_q <= ge_step ? bbpt_pkg::TESS_W'(rem2 - {1'b0, den}) : rem2[bbpt_pkg::TESS_W-1:0];
				quo_q <= {quo_q[TW-2:0], ge_step};
			end
			bbpt_pkg::OP_TWR: tp_q[cmd.pidx][0] <= quo_q;
			bbpt_pkg::OP_RD: begin
				if (cmd.step != 3'd0) begin
					if (cmd.stage == 3'(bbpt_pkg::STAGES)) begin
						p_q[kcap] <= rowv_q[kcap];
					end else begin
						case (cmd.crd)
							2'd0: p_q[kcap] <= rdata[CW-1:0];
							2'd1: p_q[kcap] <= rdata[2*CW-1:CW];
							default: p_q[kcap] <= rdata[3*CW-1:2*CW];
						endcase
					end
				end
			end
			bbpt_pkg::OP_SUM: begin
				if (cmd.stage == 3'(bbpt_pkg::STAGES)) begin
					pts_q[cmd.pt][cmd.crd] <= sat;
				end else begin
					rowv_q[cmd.stage[1:0]] <= sat;
				end
			end
			bbpt_pkg::OP_EMIT: begin
				res_q.vert_x <= pts_q[epnt][0];
				res_q.vert_y <= pts_q[epnt][1];
				res_q.vert_z <= pts_q[epnt][2];
				res_q.corner <= cmd.step;
				res_q.status <= bbpt_pkg::STATUS_OK;
				res_q.last   <= (cmd.step == 3'(bbpt_pkg::CORNERS - 1));
			end
			bbpt_pkg::OP_ERR: begin
				res_q.vert_x <= '0;
				res_q.vert_y <= '0;
				res_q.vert_z <= '0;
				res_q.corner <= '0;
				res_q.status <= bbpt_pkg::STATUS_OOR;
				res_q.last   <= 1'b1;
			end
			default: res_q <= res_q;
		endcase
	end

	assign res     = res_q;
	assign res_stb = res_stb_q;

endmodule
